@@ rtl/bblc_pkg.sv @@
// ----------------------------------------------------------------------------
// bblc_pkg
// Shared types, constants and the phrase table of the BASIC line classifier.
// ----------------------------------------------------------------------------
package bblc_pkg;

  // Line buffer geometry
  localparam int unsigned LINE_CHARS = 256;
  localparam int unsigned LEN_W      = $clog2(LINE_CHARS + 1);
  localparam int unsigned ADDR_W     = $clog2(LINE_CHARS);

  // Result codes
  localparam logic [2:0] BK_NONE = 3'd0;
  localparam logic [2:0] BK_COND = 3'd1;

  localparam logic [1:0] DISP_NONE  = 2'd0;
  localparam logic [1:0] DISP_OPEN  = 2'd1;
  localparam logic [1:0] DISP_CONT  = 2'd2;
  localparam logic [1:0] DISP_CLOSE = 2'd3;

  // Input kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LPAREN = 8'h28;

  // Phrase table: index order is the match order
  localparam int unsigned PH_W         = 6;
  localparam int unsigned PH_TXT_W     = 120;
  localparam logic [PH_W-1:0] PH_VIS_FIRST = 6'd27;
  localparam logic [PH_W-1:0] PH_LAST      = 6'd47;

  localparam logic [39:0] THEN_TXT = " THEN";
  localparam logic [3:0]  THEN_LAST = 4'd4;

  typedef enum logic [2:0] {
    SEC_REM, SEC_CLOSE, SEC_CONT, SEC_IF, SEC_VIS, SEC_OPEN
  } sect_e;

  typedef struct packed {
    logic [PH_TXT_W-1:0] txt;   // right aligned, first char leftmost
    logic [3:0]          len;
    logic [2:0]          kind;
    sect_e               sect;
  } phrase_t;

  function automatic phrase_t mk(input logic [PH_TXT_W-1:0] t, input logic [3:0] n,
                                 input logic [2:0] k, input sect_e s);
    phrase_t p;
    p.txt  = t;
    p.len  = n;
    p.kind = k;
    p.sect = s;
    return p;
  endfunction

  function automatic phrase_t phrase_get(input logic [PH_W-1:0] k);
    phrase_t p;
    case (k)
      6'd0:  p = mk("REM",             4'd3,  3'd0, SEC_REM);
      6'd1:  p = mk("END IF",          4'd6,  3'd1, SEC_CLOSE);
      6'd2:  p = mk("ENDIF",           4'd5,  3'd1, SEC_CLOSE);
      6'd3:  p = mk("END SELECT",      4'd10, 3'd2, SEC_CLOSE);
      6'd4:  p = mk("NEXT",            4'd4,  3'd3, SEC_CLOSE);
      6'd5:  p = mk("LOOP",            4'd4,  3'd3, SEC_CLOSE);
      6'd6:  p = mk("WEND",            4'd4,  3'd3, SEC_CLOSE);
      6'd7:  p = mk("END WHILE",       4'd9,  3'd3, SEC_CLOSE);
      6'd8:  p = mk("END SUB",         4'd7,  3'd4, SEC_CLOSE);
      6'd9:  p = mk("END FUNCTION",    4'd12, 3'd4, SEC_CLOSE);
      6'd10: p = mk("END PROPERTY",    4'd12, 3'd4, SEC_CLOSE);
      6'd11: p = mk("END CONSTRUCTOR", 4'd15, 3'd4, SEC_CLOSE);
      6'd12: p = mk("END DESTRUCTOR",  4'd14, 3'd4, SEC_CLOSE);
      6'd13: p = mk("END TYPE",        4'd8,  3'd5, SEC_CLOSE);
      6'd14: p = mk("END ENUM",        4'd8,  3'd5, SEC_CLOSE);
      6'd15: p = mk("END CLASS",       4'd9,  3'd5, SEC_CLOSE);
      6'd16: p = mk("END STRUCT",      4'd10, 3'd5, SEC_CLOSE);
      6'd17: p = mk("END WITH",        4'd8,  3'd6, SEC_CLOSE);
      6'd18: p = mk("END TRY",         4'd7,  3'd7, SEC_CLOSE);
      6'd19: p = mk("END",             4'd3,  3'd4, SEC_CLOSE);
      6'd20: p = mk("ELSEIF",          4'd6,  3'd1, SEC_CONT);
      6'd21: p = mk("ELSE IF",         4'd7,  3'd1, SEC_CONT);
      6'd22: p = mk("ELSE",            4'd4,  3'd1, SEC_CONT);
      6'd23: p = mk("CASE",            4'd4,  3'd2, SEC_CONT);
      6'd24: p = mk("CATCH",           4'd5,  3'd7, SEC_CONT);
      6'd25: p = mk("FINALLY",         4'd7,  3'd7, SEC_CONT);
      6'd26: p = mk("IF",              4'd2,  3'd1, SEC_IF);
      6'd27: p = mk("PUBLIC",          4'd6,  3'd0, SEC_VIS);
      6'd28: p = mk("PRIVATE",         4'd7,  3'd0, SEC_VIS);
      6'd29: p = mk("PROTECTED",       4'd9,  3'd0, SEC_VIS);
      6'd30: p = mk("STATIC",          4'd6,  3'd0, SEC_VIS);
      6'd31: p = mk("SHARED",          4'd6,  3'd0, SEC_VIS);
      6'd32: p = mk("EXPORT",          4'd6,  3'd0, SEC_VIS);
      6'd33: p = mk("SELECT CASE",     4'd11, 3'd2, SEC_OPEN);
      6'd34: p = mk("FOR",             4'd3,  3'd3, SEC_OPEN);
      6'd35: p = mk("DO",              4'd2,  3'd3, SEC_OPEN);
      6'd36: p = mk("WHILE",           4'd5,  3'd3, SEC_OPEN);
      6'd37: p = mk("SUB",             4'd3,  3'd4, SEC_OPEN);
      6'd38: p = mk("FUNCTION",        4'd8,  3'd4, SEC_OPEN);
      6'd39: p = mk("PROPERTY",        4'd8,  3'd4, SEC_OPEN);
      6'd40: p = mk("CONSTRUCTOR",     4'd11, 3'd4, SEC_OPEN);
      6'd41: p = mk("DESTRUCTOR",      4'd10, 3'd4, SEC_OPEN);
      6'd42: p = mk("TYPE",            4'd4,  3'd5, SEC_OPEN);
      6'd43: p = mk("ENUM",            4'd4,  3'd5, SEC_OPEN);
      6'd44: p = mk("CLASS",           4'd5,  3'd5, SEC_OPEN);
      6'd45: p = mk("STRUCT",          4'd6,  3'd5, SEC_OPEN);
      6'd46: p = mk("WITH",            4'd4,  3'd6, SEC_OPEN);
      6'd47: p = mk("TRY",             4'd3,  3'd7, SEC_OPEN);
      default: p = mk('0,              4'd15, 3'd0, SEC_OPEN);
    endcase
    return p;
  endfunction

  // Character classes
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return is_ws(c) || (c == 8'h0a) || (c == 8'h0b) || (c == 8'h0c);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) ? (c - 8'h20) : c;
  endfunction

endpackage

@@ rtl/bblc_if.sv @@
// ----------------------------------------------------------------------------
// bblc_if
// Valid/ready channels of the BASIC line classifier.
// ----------------------------------------------------------------------------
interface bblc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;

  modport source (output valid, kind, ch, input ready);
  modport sink   (input valid, kind, ch, output ready);
endinterface

interface bblc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] block_kind;
  logic [1:0] disposition;
  logic       overflow;

  modport source (output valid, block_kind, disposition, overflow, input ready);
  modport sink   (input valid, block_kind, disposition, overflow, output ready);
endinterface

@@ rtl/basic_block_line_classifier.sv @@
// ----------------------------------------------------------------------------
// basic_block_line_classifier
// Buffers one BASIC line, then walks it with one byte comparator to report
// the block kind and role of the line.
// ----------------------------------------------------------------------------
// Character items: taken while idle, written straight into the line buffer.
// End-of-line item: each buffer read goes through the single RAM port with a
//   registered read; trims, number skip, phrase compares of at most 16 reads
//   each and the THEN scan of at most 5 reads per position make up the walk.
// Overflowed line: result valid in the cycle after the end-of-line item.
// Reset clears all line state; the buffer contents need no clearing.
// ----------------------------------------------------------------------------
module basic_block_line_classifier (
  input logic        clk_i,
  input logic        rst_ni,
  bblc_in_if.sink    in_i,
  bblc_out_if.source out_o
);
  import bblc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TB_RD, ST_TB_CK, ST_TE_RD, ST_TE_CK, ST_DG_RD, ST_DG_CK,
    ST_PH_START, ST_PH_RD, ST_PH_CK, ST_PH_BD, ST_TH_START, ST_TH_RD, ST_TH_CK
  } state_e;

  // what follows a forward trim
  typedef enum logic [1:0] {TM_INIT, TM_NUM, TM_VIS} trim_mode_e;

  state_e           state_q, state_d;
  trim_mode_e       mode_q, mode_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] b_q, b_d, e_q, e_d, i_q, i_d;
  logic [3:0]       j_q, j_d;
  logic [PH_W-1:0]  k_q, k_d;
  logic             in_str_q, in_str_d, sjc_q, sjc_d;
  logic             cmt_q, cmt_d, ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d, out_ovf_q, out_ovf_d;
  logic [2:0]       out_bk_q, out_bk_d;
  logic [1:0]       out_disp_q, out_disp_d;

  logic              in_fire, ram_we, keep_en, done, ph_hit, ph_fail;
  logic [7:0]        keep_val, rd_data, ph_ch, then_ch;
  logic [ADDR_W-1:0] rd_addr, ram_addr;
  logic [2:0]        res_bk;
  logic [1:0]        res_disp;
  logic [6:0]        ph_bidx;
  logic [5:0]        th_bidx;
  phrase_t           ph;

  assign in_i.ready = (state_q == ST_IDLE) && !((in_i.kind == KIND_EOL) && out_valid_q);
  assign in_fire    = in_i.valid && in_i.ready;

  // Phrase and THEN character lookup
  assign ph      = phrase_get(k_q);
  assign ph_bidx = {4'(ph.len - j_q - 4'd1), 3'b000};
  assign ph_ch   = ph.txt[ph_bidx +: 8];
  assign th_bidx = {3'(THEN_LAST - j_q), 3'b000};
  assign then_ch = THEN_TXT[th_bidx +: 8];

  // Line buffer
  assign ram_addr = (state_q == ST_IDLE) ? len_q[ADDR_W-1:0] : rd_addr;

  bblc_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (keep_val),
    .rdata_o (rd_data)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    len_d       = len_q;
    b_d         = b_q;
    e_d         = e_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    in_str_d    = in_str_q;
    sjc_d       = sjc_q;
    cmt_d       = cmt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_bk_d    = out_bk_q;
    out_disp_d  = out_disp_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    keep_en     = 1'b0;
    keep_val    = in_i.ch;
    rd_addr     = '0;
    done        = 1'b0;
    ph_hit      = 1'b0;
    ph_fail     = 1'b0;
    res_bk      = BK_NONE;
    res_disp    = DISP_NONE;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.kind == KIND_CHAR) begin
            if (cmt_q) begin
              // rest of line dropped
            end else if (in_str_q) begin
              keep_en = 1'b1;
              if (in_i.ch == CH_QUOTE) begin
                in_str_d = 1'b0;
                sjc_d    = 1'b1;
              end
            end else if (sjc_q && (in_i.ch == CH_QUOTE)) begin
              keep_en  = 1'b1;
              in_str_d = 1'b1;
              sjc_d    = 1'b0;
            end else begin
              sjc_d = 1'b0;
              if (in_i.ch == CH_APOS) begin
                cmt_d = 1'b1;
              end else if (in_i.ch == CH_QUOTE) begin
                keep_en  = 1'b1;
                in_str_d = 1'b1;
              end else begin
                keep_en  = 1'b1;
                keep_val = to_upper(in_i.ch);
              end
            end
            if (keep_en) begin
              if (len_q < LEN_W'(LINE_CHARS)) begin
                ram_we = 1'b1;
                len_d  = len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end else if (ovf_q) begin
            done = 1'b1;
          end else begin
            b_d     = '0;
            e_d     = len_q;
            mode_d  = TM_INIT;
            state_d = ST_TB_RD;
          end
        end
      end

      // forward trim
      ST_TB_RD: begin
        if (b_q >= e_q) begin
          done = 1'b1;
        end else begin
          rd_addr = b_q[ADDR_W-1:0];
          state_d = ST_TB_CK;
        end
      end

      ST_TB_CK: begin
        if (is_ws(rd_data)) begin
          b_d     = b_q + 1'b1;
          state_d = ST_TB_RD;
        end else begin
          case (mode_q)
            TM_INIT: state_d = ST_TE_RD;
            TM_NUM: begin
              k_d     = '0;
              state_d = ST_PH_START;
            end
            default: begin
              k_d     = PH_VIS_FIRST;
              state_d = ST_PH_START;
            end
          endcase
        end
      end

      // backward trim; a non-blank char at b stops it
      ST_TE_RD: begin
        rd_addr = ADDR_W'(e_q - 1'b1);
        state_d = ST_TE_CK;
      end

      ST_TE_CK: begin
        if (is_ws(rd_data)) begin
          e_d     = e_q - 1'b1;
          state_d = ST_TE_RD;
        end else begin
          i_d     = b_q;
          state_d = ST_DG_RD;
        end
      end

      // leading line number
      ST_DG_RD: begin
        if (i_q >= e_q) begin
          k_d     = '0;
          state_d = ST_PH_START;
        end else begin
          rd_addr = i_q[ADDR_W-1:0];
          state_d = ST_DG_CK;
        end
      end

      ST_DG_CK: begin
        if ((rd_data >= 8'h30) && (rd_data <= 8'h39)) begin
          i_d     = i_q + 1'b1;
          state_d = ST_DG_RD;
        end else if ((i_q != b_q) && is_ws(rd_data)) begin
          b_d     = i_q;
          mode_d  = TM_NUM;
          state_d = ST_TB_RD;
        end else begin
          k_d     = '0;
          state_d = ST_PH_START;
        end
      end

      // phrase compare at b
      ST_PH_START: begin
        if ((e_q - b_q) < LEN_W'(ph.len)) begin
          ph_fail = 1'b1;
        end else begin
          j_d     = '0;
          state_d = ST_PH_RD;
        end
      end

      ST_PH_RD: begin
        rd_addr = ADDR_W'(b_q + LEN_W'(j_q));
        state_d = ST_PH_CK;
      end

      ST_PH_CK: begin
        if (rd_data != ph_ch) begin
          ph_fail = 1'b1;
        end else if ((j_q + 4'd1) == ph.len) begin
          if ((b_q + LEN_W'(ph.len)) == e_q) begin
            ph_hit = 1'b1;
          end else begin
            rd_addr = ADDR_W'(b_q + LEN_W'(ph.len));
            state_d = ST_PH_BD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_PH_RD;
        end
      end

      // word boundary after the phrase
      ST_PH_BD: begin
        if (is_space(rd_data) || (rd_data == CH_COLON) || (rd_data == CH_LPAREN)) begin
          ph_hit = 1'b1;
        end else begin
          ph_fail = 1'b1;
        end
      end

      // first " THEN" must end the line
      ST_TH_START: begin
        if (({1'b0, i_q} + (LEN_W+1)'(5)) > {1'b0, e_q}) begin
          k_d     = PH_VIS_FIRST;
          state_d = ST_PH_START;
        end else begin
          j_d     = '0;
          state_d = ST_TH_RD;
        end
      end

      ST_TH_RD: begin
        rd_addr = ADDR_W'(i_q + LEN_W'(j_q));
        state_d = ST_TH_CK;
      end

      ST_TH_CK: begin
        if (rd_data != then_ch) begin
          i_d     = i_q + 1'b1;
          state_d = ST_TH_START;
        end else if (j_q == THEN_LAST) begin
          if ((i_q + LEN_W'(5)) == e_q) begin
            done     = 1'b1;
            res_bk   = BK_COND;
            res_disp = DISP_OPEN;
          end else begin
            k_d     = PH_VIS_FIRST;
            state_d = ST_PH_START;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_TH_RD;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // phrase outcome
    if (ph_fail) begin
      if (k_q == PH_LAST) begin
        done = 1'b1;
      end else begin
        k_d     = k_q + 1'b1;
        state_d = ST_PH_START;
      end
    end
    if (ph_hit) begin
      case (ph.sect)
        SEC_REM:   done = 1'b1;
        SEC_CLOSE: begin
          done     = 1'b1;
          res_bk   = ph.kind;
          res_disp = DISP_CLOSE;
        end
        SEC_CONT: begin
          done     = 1'b1;
          res_bk   = ph.kind;
          res_disp = DISP_CONT;
        end
        SEC_IF: begin
          i_d     = b_q;
          state_d = ST_TH_START;
        end
        SEC_VIS: begin
          b_d     = b_q + LEN_W'(ph.len);
          mode_d  = TM_VIS;
          state_d = ST_TB_RD;
        end
        default: begin
          done     = 1'b1;
          res_bk   = ph.kind;
          res_disp = DISP_OPEN;
        end
      endcase
    end

    // publish result and clear line state
    if (done) begin
      out_valid_d = 1'b1;
      out_bk_d    = res_bk;
      out_disp_d  = res_disp;
      out_ovf_d   = ovf_q;
      len_d       = '0;
      in_str_d    = 1'b0;
      sjc_d       = 1'b0;
      cmt_d       = 1'b0;
      ovf_d       = 1'b0;
      state_d     = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= TM_INIT;
      len_q       <= '0;
      in_str_q    <= 1'b0;
      sjc_q       <= 1'b0;
      cmt_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      b_q         <= '0;
      e_q         <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      len_q       <= len_d;
      in_str_q    <= in_str_d;
      sjc_q       <= sjc_d;
      cmt_q       <= cmt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      b_q         <= b_d;
      e_q         <= e_d;
    end
  end

  // walk pointers and result payload
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    out_bk_q   <= out_bk_d;
    out_disp_q <= out_disp_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.block_kind  = out_bk_q;
  assign out_o.disposition = out_disp_q;
  assign out_o.overflow    = out_ovf_q;

  // Checks
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input ready while classifying");

  a_ovf_gives_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ovf_q) |-> ((out_bk_q == BK_NONE) && (out_disp_q == DISP_NONE)))
    else $error("overflowed line gave a classification");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_CHARS))
    else $error("line length beyond buffer");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_IDLE) && (state_q != ST_TB_RD)) |-> (b_q < e_q))
    else $error("empty scan window inside walk");

endmodule

@@ rtl/bblc_ram.sv @@
// ----------------------------------------------------------------------------
// bblc_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bblc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/bblc_checker.sv @@
// ----------------------------------------------------------------------------
// bblc_checker
// Watches both channels of the BASIC line classifier, rebuilds each line as
// it is accepted, classifies it at end of line and compares the result items
// field by field against the block's output in arrival order.
// ----------------------------------------------------------------------------
module bblc_checker
  import bblc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bblc_in_if         in_i,
  bblc_out_if        out_o,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] block_kind;
    logic [1:0] disposition;
    logic       overflow;
  } line_class_t;

  line_class_t class_q[$];

  // Shadow line state
  logic [7:0]  line_buf [LINE_CHARS];
  int unsigned line_len;
  logic        quoted, quote_closed, remark, spilled;

  assign pending_o = class_q.size();

  function automatic bit ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d;
  endfunction

  function automatic bit sep(input logic [7:0] c);
    return ws(c) || c == 8'h0a || c == 8'h0b || c == 8'h0c || c == CH_COLON ||
           c == CH_LPAREN;
  endfunction

  // Phrase test at position b of the kept text ending at e
  function automatic bit word_at(input int unsigned b, input int unsigned e,
                                 input string w);
    if (e < b || e - b < w.len()) return 0;
    for (int i = 0; i < w.len(); i++)
      if (line_buf[b + i] != w[i]) return 0;
    if (e - b == w.len()) return 1;
    return sep(line_buf[b + w.len()]);
  endfunction

  function automatic bit text_at(input int unsigned p, input int unsigned e,
                                 input string w);
    if (e < p || e - p < w.len()) return 0;
    for (int i = 0; i < w.len(); i++)
      if (line_buf[p + i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic line_class_t classify_line();
    string closers[19] = '{"END IF", "ENDIF", "END SELECT", "NEXT", "LOOP", "WEND",
      "END WHILE", "END SUB", "END FUNCTION", "END PROPERTY", "END CONSTRUCTOR",
      "END DESTRUCTOR", "END TYPE", "END ENUM", "END CLASS", "END STRUCT",
      "END WITH", "END TRY", "END"};
    int closer_kind[19] = '{1, 1, 2, 3, 3, 3, 3, 4, 4, 4, 4, 4, 5, 5, 5, 5, 6, 7, 4};
    string conts[6] = '{"ELSEIF", "ELSE IF", "ELSE", "CASE", "CATCH", "FINALLY"};
    int cont_kind[6] = '{1, 1, 1, 2, 7, 7};
    string openers[15] = '{"SELECT CASE", "FOR", "DO", "WHILE", "SUB", "FUNCTION",
      "PROPERTY", "CONSTRUCTOR", "DESTRUCTOR", "TYPE", "ENUM", "CLASS", "STRUCT",
      "WITH", "TRY"};
    int opener_kind[15] = '{2, 3, 3, 3, 4, 4, 4, 4, 4, 5, 5, 5, 5, 6, 7};
    string vis[6] = '{"PUBLIC", "PRIVATE", "PROTECTED", "STATIC", "SHARED", "EXPORT"};
    line_class_t r;
    int unsigned b, e, i, p, q;
    bit hit;
    r = '0;
    b = 0;
    e = line_len;
    while (b < e && ws(line_buf[b])) b++;
    while (e > b && ws(line_buf[e-1])) e--;
    // drop a leading line number
    i = b;
    while (i < e && line_buf[i] >= "0" && line_buf[i] <= "9") i++;
    if (i != b && i != e && ws(line_buf[i])) begin
      b = i;
      while (b < e && ws(line_buf[b])) b++;
    end
    if (b == e) return r;
    if (line_buf[b] == CH_APOS || word_at(b, e, "REM")) return r;
    foreach (closers[k])
      if (word_at(b, e, closers[k])) begin
        r.block_kind = closer_kind[k];
        r.disposition = DISP_CLOSE;
        return r;
      end
    foreach (conts[k])
      if (word_at(b, e, conts[k])) begin
        r.block_kind = cont_kind[k];
        r.disposition = DISP_CONT;
        return r;
      end
    // IF ... THEN with nothing after THEN
    if (word_at(b, e, "IF")) begin
      p = b;
      while (p + 5 <= e && !text_at(p, e, " THEN")) p++;
      if (p + 5 <= e) begin
        q = p + 5;
        while (q < e && ws(line_buf[q])) q++;
        if (q == e) begin
          r.block_kind = BK_COND;
          r.disposition = DISP_OPEN;
          return r;
        end
      end
    end
    // strip visibility prefixes
    do begin
      hit = 0;
      foreach (vis[k])
        if (!hit && word_at(b, e, vis[k])) begin
          b += vis[k].len();
          while (b < e && ws(line_buf[b])) b++;
          hit = 1;
        end
    end while (hit);
    foreach (openers[k])
      if (word_at(b, e, openers[k])) begin
        r.block_kind = opener_kind[k];
        r.disposition = DISP_OPEN;
        return r;
      end
    return r;
  endfunction

  function automatic void keep_char(input logic [7:0] c);
    if (line_len < LINE_CHARS) begin
      line_buf[line_len] = c;
      line_len++;
    end else spilled = 1;
  endfunction

  // Input side: track the line and predict at end of line
  always @(posedge clk_i or negedge rst_ni) begin
    line_class_t r;
    if (!rst_ni) begin
      line_len = 0;
      quoted = 0;
      quote_closed = 0;
      remark = 0;
      spilled = 0;
    end else if (in_i.valid && in_i.ready) begin
      if (in_i.kind == KIND_CHAR) begin
        if (remark) begin
        end else if (quoted) begin
          keep_char(in_i.ch);
          if (in_i.ch == CH_QUOTE) begin
            quoted = 0;
            quote_closed = 1;
          end
        end else if (quote_closed && in_i.ch == CH_QUOTE) begin
          keep_char(in_i.ch);
          quoted = 1;
          quote_closed = 0;
        end else begin
          quote_closed = 0;
          if (in_i.ch == CH_APOS) remark = 1;
          else if (in_i.ch == CH_QUOTE) begin
            keep_char(in_i.ch);
            quoted = 1;
          end else if (in_i.ch >= "a" && in_i.ch <= "z") keep_char(in_i.ch - 8'h20);
          else keep_char(in_i.ch);
        end
      end else begin
        r = '0;
        if (spilled) r.overflow = 1;
        else r = classify_line();
        class_q.insert(class_q.size(), r);
        line_len = 0;
        quoted = 0;
        quote_closed = 0;
        remark = 0;
        spilled = 0;
      end
    end
  end

  // Output side: compare with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    line_class_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else if (out_o.valid && out_o.ready) begin
      if (class_q.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10)
          $display("unexpected result item: kind %0d disp %0d ovf %0d",
                   out_o.block_kind, out_o.disposition, out_o.overflow);
      end else begin
        want = class_q.pop_front();
        if (want.block_kind !== out_o.block_kind ||
            want.disposition !== out_o.disposition ||
            want.overflow !== out_o.overflow) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("mismatch: expected kind %0d disp %0d ovf %0d, got %0d %0d %0d",
                     want.block_kind, want.disposition, want.overflow,
                     out_o.block_kind, out_o.disposition, out_o.overflow);
        end
      end
    end
  end
endmodule

@@ tb/basic_block_line_classifier_test.sv @@
// ----------------------------------------------------------------------------
// basic_block_line_classifier_test
// Sends directed and random BASIC lines through the classifier with random
// gaps on both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module basic_block_line_classifier_test;
  import bblc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   lines_sent;

  bblc_in_if  in_ch ();
  bblc_out_if out_ch ();

  basic_block_line_classifier DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  bblc_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_o        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One input item; gap before it, valid held until accepted
  task automatic send_item(input logic k, input logic [7:0] c);
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.kind  <= k;
    in_ch.ch    <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
    send_item(KIND_EOL, 8'($urandom_range(0, 255)));
    lines_sent++;
  endtask

  // Random casing plus optional padding
  function automatic string mangle(input string s);
    string o;
    o = "";
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] >= "A" && s[i] <= "Z" && $urandom_range(0, 1))
        o = {o, string'(s[i] + 8'h20)};
      else o = {o, string'(s[i])};
    end
    return o;
  endfunction

  function automatic string pad();
    string o;
    string w[3] = '{" ", "\t", "\r"};
    o = "";
    repeat ($urandom_range(0, 2)) o = {o, w[$urandom_range(0, 2)]};
    return o;
  endfunction

  function automatic string rand_line();
    string kw[50] = '{"END IF", "ENDIF", "END SELECT", "NEXT", "LOOP", "WEND",
      "END WHILE", "END SUB", "END FUNCTION", "END PROPERTY", "END CONSTRUCTOR",
      "END DESTRUCTOR", "END TYPE", "END ENUM", "END CLASS", "END STRUCT",
      "END WITH", "END TRY", "END", "ELSEIF", "ELSE IF", "ELSE", "CASE", "CATCH",
      "FINALLY", "SELECT CASE", "FOR", "DO", "WHILE", "SUB", "FUNCTION",
      "PROPERTY", "CONSTRUCTOR", "DESTRUCTOR", "TYPE", "ENUM", "CLASS", "STRUCT",
      "WITH", "TRY", "IF", "REM", "PUBLIC", "PRIVATE", "PROTECTED", "STATIC",
      "SHARED", "EXPORT", "ENDX", "FORM"};
    string tails[10] = '{"", " X = 1", ":", "(A)", " THEN", " THEN ", " \"S\"\"T\"",
      " ' note", "\tY", " THENX"};
    string s;
    int r;
    s = pad();
    if ($urandom_range(0, 3) == 0) s = {s, $sformatf("%0d ", $urandom_range(0, 9999))};
    r = $urandom_range(0, 9);
    if (r < 2) s = {s, kw[$urandom_range(42, 47)], " "};
    if (r == 9) begin
      // noise bytes, any nonzero value possible
      repeat ($urandom_range(0, 12)) s = {s, string'(8'($urandom_range(1, 255)))};
      return s;
    end
    s = {s, kw[$urandom_range(0, 49)]};
    if (s.len() > 0 && s.substr(s.len() - 2, s.len() - 1) == "IF" && $urandom_range(0, 1))
      s = {s, " A", tails[$urandom_range(4, 5)]};
    else s = {s, tails[$urandom_range(0, 9)]};
    return {mangle(s), pad()};
  endfunction

  // Output stall: ready low for a random gap, which may be empty, then high
  initial begin
    int g;
    out_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(negedge clk_i);
      end
      out_ch.ready <= 1;
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    string s;
    int guard;
    in_ch.valid = 0;
    in_ch.kind  = KIND_CHAR;
    in_ch.ch    = 0;
    lines_sent  = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed lines
    send_line("");
    send_line("   \t\r ");
    send_line("10 if a = 1 then");
    send_line("IF X THEN PRINT 1");
    send_line("rem hello");
    send_line("' whole comment");
    send_line("End If");
    send_line("end");
    send_line("ELSE IF x");
    send_line("public static sub Foo()");
    send_line("PRINT \"end \"\"if\"\" do\" 'for");
    send_line("for i=1 to 9 'x \" y");
    send_line("123");
    send_line("select case a");
    send_line("\xffDO\x01");
    send_line("WITH:x");
    send_line("try\t");
    // full buffer, then a comment that must not spill
    s = "";
    repeat (256) s = {s, "a"};
    send_line({s, "'zzzz"});
    // one character past the buffer
    send_line({s, "b"});
    send_line({"END", string'(8'h0b)});

    // random lines
    for (int n = 0; n < 10; n++) send_line(rand_line());
    @(negedge clk_i);
    in_ch.valid <= 0;

    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("** basic_block_line_classifier: PASSED **");
    else $display("** basic_block_line_classifier: FAILED **");
    $finish;
  end

  initial begin
    #40ms;
    $display("** basic_block_line_classifier: FAILED **");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/bblc_pkg.sv
rtl/bblc_if.sv
rtl/bblc_ram.sv
rtl/basic_block_line_classifier.sv
tb/bblc_checker.sv
tb/basic_block_line_classifier_test.sv
